### rtl/core/alis_pkg.sv
// Shared types and constants for the array list insert/shift unit.
// No dependencies.
`default_nettype none
package alis_pkg;

    localparam int ALIS_CAPACITY = 16;
    localparam int DATA_W        = 32;
    // Width of internal slot arithmetic: holds any slot index plus a position.
    localparam int CTL_W         = 10;

    typedef enum logic [1:0] {
        CMD_FRONT = 2'd0,
        CMD_BACK  = 2'd1,
        CMD_POS   = 2'd2,
        CMD_READ  = 2'd3
    } alis_cmd_t;

    // Broadcast to every cell in the row for one beat.
    typedef struct packed {
        logic              wr_en;
        logic              up_en;
        logic              dn_en;
        logic [CTL_W-1:0]  wr_idx;
        logic [CTL_W-1:0]  lo;
        logic [CTL_W-1:0]  hi;
        logic [DATA_W-1:0] wr_data;
    } alis_shift_t;

endpackage
`default_nettype wire

### rtl/core/alis_cell.sv
// One slot of the list row: holds a value, loads, or takes a neighbor's value.
// Depends on alis_pkg.
`default_nettype none
module alis_cell #(
    parameter int IDX = 0
) (
    input  wire                        aclk,
    input  alis_pkg::alis_shift_t      ctrl,
    input  wire [alis_pkg::DATA_W-1:0] left_data,
    input  wire [alis_pkg::DATA_W-1:0] right_data,
    output logic [alis_pkg::DATA_W-1:0] data_out
);
    import alis_pkg::*;

    localparam logic [CTL_W-1:0] MY_IDX = CTL_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              in_range;

    assign in_range = (MY_IDX >= ctrl.lo) && (MY_IDX <= ctrl.hi);

    always_comb begin
        data_next = data_reg;
        if (ctrl.wr_en && ctrl.wr_idx == MY_IDX) begin
            data_next = ctrl.wr_data;
        end else if (ctrl.up_en && in_range) begin
            data_next = left_data;
        end else if (ctrl.dn_en && in_range) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule
`default_nettype wire

### rtl/core/alis_ctrl.sv
// Command decode: next head/tail/empty, status, and the shift control for the row.
// Depends on alis_pkg.
`default_nettype none
module alis_ctrl #(
    parameter int CAPACITY = alis_pkg::ALIS_CAPACITY,
    parameter int IDX_W    = $clog2(CAPACITY)
) (
    input  wire                        accept,
    input  wire [1:0]                  cmd,
    input  wire [4:0]                  position,
    input  wire [3:0]                  slot,
    input  wire [alis_pkg::DATA_W-1:0] value,
    input  wire [IDX_W-1:0]            head,
    input  wire [IDX_W-1:0]            tail,
    input  wire                        empty,
    output logic                       ok,
    output logic [IDX_W-1:0]           head_next,
    output logic [IDX_W-1:0]           tail_next,
    output logic                       empty_next,
    output alis_pkg::alis_shift_t      ctrl
);
    import alis_pkg::*;

    localparam logic [CTL_W-1:0] LAST = CTL_W'(CAPACITY - 1);
    localparam logic [CTL_W-1:0] CAP  = CTL_W'(CAPACITY);
    localparam logic [CTL_W-1:0] ONE  = CTL_W'(1);
    localparam logic [CTL_W-1:0] TWO  = CTL_W'(2);
    localparam logic [CTL_W-1:0] ZERO = '0;

    alis_cmd_t        op;
    logic [CTL_W-1:0] h, t, p, s, count, nh, nt;
    logic             full, ne, wr_en, up_en, dn_en;
    logic [CTL_W-1:0] wr_idx, lo, hi;

    assign op    = alis_cmd_t'(cmd);
    assign h     = CTL_W'(head);
    assign t     = CTL_W'(tail);
    assign p     = CTL_W'(position);
    assign s     = CTL_W'(slot);
    assign count = t - h + ONE;
    assign full  = !empty && h == ZERO && t == LAST;

    always_comb begin
        ok     = 1'b0;
        nh     = h;
        nt     = t;
        ne     = empty;
        wr_en  = 1'b0;
        up_en  = 1'b0;
        dn_en  = 1'b0;
        wr_idx = ZERO;
        lo     = ZERO;
        hi     = ZERO;
        case (op)
            CMD_READ: begin
                ok = !empty && s < CAP && s >= h && s <= t;
            end
            CMD_FRONT, CMD_BACK: begin
                if (!full) begin
                    ok    = 1'b1;
                    wr_en = 1'b1;
                    if (empty) begin
                        nh = ZERO;
                        nt = ZERO;
                        ne = 1'b0;
                    end else if (op == CMD_FRONT) begin
                        if (h != ZERO) begin
                            nh     = h - ONE;
                            wr_idx = h - ONE;
                        end else begin
                            // no room in front: push the run up one slot
                            up_en  = 1'b1;
                            lo     = ONE;
                            hi     = t + ONE;
                            nt     = t + ONE;
                        end
                    end else begin
                        if (t != LAST) begin
                            nt     = t + ONE;
                            wr_idx = t + ONE;
                        end else begin
                            // no room at back: pull the run down one slot
                            dn_en  = 1'b1;
                            lo     = h - ONE;
                            hi     = t - ONE;
                            nh     = h - ONE;
                            wr_idx = t;
                        end
                    end
                end
            end
            CMD_POS: begin
                if (!full) begin
                    if (empty) begin
                        if (p == ONE) begin
                            ok    = 1'b1;
                            wr_en = 1'b1;
                            nh    = ZERO;
                            nt    = ZERO;
                            ne    = 1'b0;
                        end
                    end else if (p >= ONE && p <= count) begin
                        ok    = 1'b1;
                        wr_en = 1'b1;
                        if (t != LAST) begin
                            up_en  = 1'b1;
                            lo     = h + p;
                            hi     = t + ONE;
                            nt     = t + ONE;
                            wr_idx = h + p - ONE;
                        end else begin
                            dn_en  = (p >= TWO);
                            lo     = h - ONE;
                            hi     = h + p - CTL_W'(3);
                            nh     = h - ONE;
                            wr_idx = h + p - TWO;
                        end
                    end
                end
            end
            default: begin
                ok = 1'b0;
            end
        endcase
    end

    assign head_next  = IDX_W'(nh);
    assign tail_next  = IDX_W'(nt);
    assign empty_next = ne;

    always_comb begin
        ctrl.wr_en   = wr_en & accept;
        ctrl.up_en   = up_en & accept;
        ctrl.dn_en   = dn_en & accept;
        ctrl.wr_idx  = wr_idx;
        ctrl.lo      = lo;
        ctrl.hi      = hi;
        ctrl.wr_data = value;
    end

endmodule
`default_nettype wire

### rtl/core/array_list_insert_shift_unit.sv
// Array list insert/shift unit: top level with the cell row and result register.
// Depends on alis_pkg, alis_ctrl and alis_cell.
// Each result beat is registered: it shows in the cycle after its beat is accepted.
// Throughput: one beat per cycle while m_ready is high; every slot shifts at once.
// Reset: list empty, head and tail at slot 0, no result pending, input held off;
// slot contents are not cleared (only slots inside the list are ever read).
`default_nettype none
module array_list_insert_shift_unit #(
    parameter int CAPACITY = alis_pkg::ALIS_CAPACITY
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  wire  [1:0]         s_cmd,
    input  wire  [4:0]         s_position,
    input  wire  [3:0]         s_slot,
    input  wire  signed [31:0] s_value,
    output logic               m_valid,
    input  wire                m_ready,
    output logic               m_ok,
    output logic signed [31:0] m_read_value,
    output logic [3:0]         m_head,
    output logic [3:0]         m_tail,
    output logic               m_empty_res
);
    import alis_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // List bounds
    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             empty_reg, empty_next;

    // Result register
    logic              valid_reg, valid_next;
    logic              ok_reg;
    logic [DATA_W-1:0] rd_reg;
    logic [3:0]        head_out_reg, tail_out_reg;
    logic              empty_out_reg;

    logic              accept;
    logic              ok;
    logic [DATA_W-1:0] rd_value;
    alis_shift_t       ctrl;
    logic [DATA_W-1:0] cell_q [CAPACITY];
    logic [CTL_W-1:0]  slot_ext;

    // Take a new beat whenever the result register is free or draining;
    // hold the input off while reset is asserted.
    assign s_ready = aresetn && (!valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    alis_ctrl #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_ctrl (
        .accept     (accept),
        .cmd        (s_cmd),
        .position   (s_position),
        .slot       (s_slot),
        .value      (DATA_W'(s_value)),
        .head       (head_reg),
        .tail       (tail_reg),
        .empty      (empty_reg),
        .ok         (ok),
        .head_next  (head_next),
        .tail_next  (tail_next),
        .empty_next (empty_next),
        .ctrl       (ctrl)
    );

    // Row of slot cells; each sees its two neighbors, the ends see zero.
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [DATA_W-1:0] left_d, right_d;
        if (i == 0) begin : g_lo_end
            assign left_d = '0;
        end else begin : g_lo_mid
            assign left_d = cell_q[i-1];
        end
        if (i == CAPACITY - 1) begin : g_hi_end
            assign right_d = '0;
        end else begin : g_hi_mid
            assign right_d = cell_q[i+1];
        end
        alis_cell #(
            .IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .data_out   (cell_q[i])
        );
    end

    // Read select from the current row; drop the value when the slot misses the list.
    assign slot_ext = CTL_W'(s_slot);
    always_comb begin
        rd_value = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (slot_ext == CTL_W'(i)) begin
                rd_value = cell_q[i];
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            empty_reg <= 1'b1;
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (accept) begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                empty_reg <= empty_next;
            end
        end
    end

    // Hold the result payload until the next accepted beat.
    always_ff @(posedge aclk) begin
        if (accept) begin
            ok_reg        <= ok;
            rd_reg        <= (ok && s_cmd == CMD_READ) ? rd_value : '0;
            head_out_reg  <= 4'(head_next);
            tail_out_reg  <= 4'(tail_next);
            empty_out_reg <= empty_next;
        end
    end

    assign m_valid      = valid_reg;
    assign m_ok         = ok_reg;
    assign m_read_value = rd_reg;
    assign m_head       = head_out_reg;
    assign m_tail       = tail_out_reg;
    assign m_empty_res  = empty_out_reg;

endmodule
`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for array_list_insert_shift_unit: a directed burst,
// then random beats, all predicted and checked by a scoreboard class.
// Depends on alis_pkg and the unit itself.
`default_nettype none
module testbench;
    import alis_pkg::*;

    localparam int TOTAL_BEATS = 700;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 48;

    // One result beat as the unit should present it.
    typedef struct {
        logic        ok;
        logic [31:0] rd;
        logic [3:0]  head;
        logic [3:0]  tail;
        logic        empty;
    } list_view_t;

    // Own copy of the slot array plus head/tail/empty; each accepted command
    // advances it and queues the result beat it should produce.
    class list_scoreboard;
        logic [31:0] cells [ALIS_CAPACITY];
        int          head_i;
        int          tail_i;
        bit          vacant;
        list_view_t  due_results [$];
        int          errors;

        function new();
            head_i = 0;
            tail_i = 0;
            vacant = 1'b1;
            errors = 0;
            foreach (cells[i]) cells[i] = '0;
        endfunction

        function int length();
            return vacant ? 0 : tail_i - head_i + 1;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function bit is_full();
            return !vacant && head_i == 0 && tail_i == ALIS_CAPACITY - 1;
        endfunction

        function void shift_up(int lo, int hi);
            for (int i = hi + 1; i > lo; i--) cells[i] = cells[i-1];
        endfunction

        function void shift_down(int lo, int hi);
            for (int i = lo; i <= hi; i++) cells[i-1] = cells[i];
        endfunction

        function void seed_list(logic [31:0] v);
            head_i   = 0;
            tail_i   = 0;
            vacant   = 1'b0;
            cells[0] = v;
        endfunction

        function void take_command(alis_cmd_t cmd, logic [4:0] pos, logic [3:0] slot,
                                   logic [31:0] v);
            list_view_t r;
            int         p;
            int         s;
            p    = pos;
            s    = slot;
            r.ok = 1'b0;
            r.rd = '0;
            if (cmd == CMD_READ) begin
                if (!vacant && s >= head_i && s <= tail_i) begin
                    r.ok = 1'b1;
                    r.rd = cells[s];
                end
            end else if (!is_full()) begin
                case (cmd)
                    CMD_FRONT: begin
                        r.ok = 1'b1;
                        if (vacant) begin
                            seed_list(v);
                        end else begin
                            if (head_i > 0) begin
                                head_i--;
                            end else begin
                                shift_up(head_i, tail_i);
                                tail_i++;
                            end
                            cells[head_i] = v;
                        end
                    end
                    CMD_BACK: begin
                        r.ok = 1'b1;
                        if (vacant) begin
                            seed_list(v);
                        end else begin
                            if (tail_i < ALIS_CAPACITY - 1) begin
                                tail_i++;
                            end else begin
                                shift_down(head_i, tail_i);
                                head_i--;
                            end
                            cells[tail_i] = v;
                        end
                    end
                    default: begin
                        if (vacant) begin
                            if (p == 1) begin
                                r.ok = 1'b1;
                                seed_list(v);
                            end
                        end else if (p >= 1 && p <= length()) begin
                            r.ok = 1'b1;
                            if (tail_i < ALIS_CAPACITY - 1) begin
                                shift_up(head_i + p - 1, tail_i);
                                tail_i++;
                            end else begin
                                if (p >= 2) shift_down(head_i, head_i + p - 2);
                                head_i--;
                            end
                            cells[head_i + p - 1] = v;
                        end
                    end
                endcase
            end
            r.head  = head_i[3:0];
            r.tail  = tail_i[3:0];
            r.empty = vacant;
            due_results.push_back(r);
        endfunction

        function void check_beat(logic ok, logic [31:0] rd, logic [3:0] head,
                                 logic [3:0] tail, logic empty);
            list_view_t w;
            if (due_results.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result beat with none expected: ok=%0b rd=%h head=%0d tail=%0d",
                             ok, rd, head, tail);
                return;
            end
            w = due_results.pop_front();
            if (ok !== w.ok || rd !== w.rd || head !== w.head || tail !== w.tail ||
                empty !== w.empty) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp ok=%0b rd=%h h=%0d t=%0d e=%0b / got ok=%0b rd=%h h=%0d t=%0d e=%0b",
                             w.ok, w.rd, w.head, w.tail, w.empty,
                             ok, rd, head, tail, empty);
            end
        endfunction
    endclass

    logic               aclk         = 1'b0;
    logic               aresetn      = 1'b0;
    logic               s_valid      = 1'b0;
    logic               s_ready;
    logic [1:0]         s_cmd        = '0;
    logic [4:0]         s_position   = '0;
    logic [3:0]         s_slot       = '0;
    logic signed [31:0] s_value      = '0;
    logic               m_valid;
    logic               m_ready      = 1'b0;
    logic               m_ok;
    logic signed [31:0] m_read_value;
    logic [3:0]         m_head;
    logic [3:0]         m_tail;
    logic               m_empty_res;

    list_scoreboard sb = new();

    // Handshake knobs shared between the sender and the result sink.
    int  hold_req   = 0;     // bump to ask the sink for one long hold-off
    int  hold_seen  = 0;
    int  hold_left  = 0;
    int  stall_left = 0;
    bit  calm       = 1'b0;  // set for the closing stretch: no idling at all
    int  cycles     = 0;

    array_list_insert_shift_unit dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_cmd        (s_cmd),
        .s_position   (s_position),
        .s_slot       (s_slot),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_ok         (m_ok),
        .m_read_value (m_read_value),
        .m_head       (m_head),
        .m_tail       (m_tail),
        .m_empty_res  (m_empty_res)
    );

    always #10 aclk = ~aclk;

    // Watchdog: end the run if the handshakes stop making progress.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result sink: check every accepted beat against the oldest prediction,
    // then decide m_ready for the next edge. A long hold-off, when asked for,
    // is counted down here so the sender keeps pushing while the unit backs up.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                sb.check_beat(m_ok, m_read_value, m_head, m_tail, m_empty_res);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                // Start a stall burst: drop m_ready now, stall_left holds the rest of it.
                stall_left = $urandom_range(1, 7) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Offer one beat and hold it until the unit takes it, then predict.
    task automatic send_beat(alis_cmd_t cmd, int pos, int slot, logic [31:0] v);
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_position <= pos[4:0];
        s_slot     <= slot[3:0];
        s_value    <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.take_command(cmd, pos[4:0], slot[3:0], v);
    endtask

    // Drop valid for an idle burst of randomly drawn length.
    task automatic idle_burst();
        int n;
        n = $urandom_range(1, 7);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Random beat. Reads make up about half; positions mostly land inside
    // the current list so inserts go through until the array fills, with
    // some out-of-range and zero positions mixed in.
    task automatic random_beat();
        alis_cmd_t   cmd;
        int          pos;
        int          len;
        logic [31:0] v;
        len = sb.length();
        case ($urandom_range(0, 5))
            0, 1, 2: cmd = CMD_READ;
            3:       cmd = CMD_FRONT;
            4:       cmd = CMD_BACK;
            default: cmd = CMD_POS;
        endcase
        if ($urandom_range(0, 4) == 0)
            pos = $urandom_range(0, 16);
        else
            pos = $urandom_range(1, (len == 0) ? 1 : len);
        case ($urandom_range(0, 7))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7fff_ffff;
            2:       v = 32'hffff_ffff;
            default: v = $urandom();
        endcase
        send_beat(cmd, pos, $urandom_range(0, 15), v);
    endtask

    initial begin
        // Hold reset, then release it once for good.
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: reads and position inserts against an empty list first, then the
        // position rules once the list holds a few elements.
        send_beat(CMD_READ,  0,  0,  32'h0);           // read while empty
        send_beat(CMD_READ,  0, 15,  32'h0);
        send_beat(CMD_POS,   0,  0,  32'h1111_1111);   // position zero
        send_beat(CMD_POS,   2,  0,  32'h2222_2222);   // empty list, not first
        send_beat(CMD_POS,  16,  0,  32'h3333_3333);
        send_beat(CMD_POS,   1,  0,  32'h8000_0000);   // starts the list
        send_beat(CMD_READ,  0,  0,  32'h0);
        send_beat(CMD_FRONT, 0,  0,  32'h7fff_ffff);   // head at slot 0: shift up
        send_beat(CMD_BACK,  0,  0,  32'hffff_ffff);
        send_beat(CMD_POS,   0,  0,  32'h4444_4444);   // position zero, non-empty
        send_beat(CMD_POS,   4,  0,  32'h5555_5555);   // beyond the list
        send_beat(CMD_POS,   3,  0,  32'h0000_0000);   // before the last element
        send_beat(CMD_POS,   1,  0,  32'h0000_0001);   // before the first element
        send_beat(CMD_READ,  0, 15,  32'h0);           // past the tail
        for (int s = 0; s < 5; s++)
            send_beat(CMD_READ, 0, s, 32'h0);
        send_beat(CMD_POS,  16,  0,  32'h6666_6666);

        for (int i = 20; i < TOTAL_BEATS; i++) begin
            if (i == 200)
                hold_req <= hold_req + 1;       // sink stalls, sender keeps going
            if (i == 450) begin
                // Drain completely before going on.
                s_valid <= 1'b0;
                @(posedge aclk);
                while (sb.pending() != 0) @(posedge aclk);
            end
            if (i == TOTAL_BEATS - 100)
                calm <= 1'b1;
            if (i >= TOTAL_BEATS - 100 || (i >= 200 && i < 260)) begin
                // No gaps here.
            end else if ($urandom_range(0, 3) == 0) begin
                idle_burst();
            end
            random_beat();
        end

        // Drain: wait for every predicted beat, then let the unit sit quiet.
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

### files.f
rtl/core/alis_pkg.sv
rtl/core/alis_cell.sv
rtl/core/alis_ctrl.sv
rtl/core/array_list_insert_shift_unit.sv
verif/testbench.sv
